@@ rtl/core/data_format_string_compiler_core_defines.svh @@
// Assertion macros shared by the format string compiler RTL.
// Synthesis builds see empty bodies.
`ifndef DATA_FORMAT_STRING_COMPILER_CORE_DEFINES_SVH
`define DATA_FORMAT_STRING_COMPILER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset
`define DFSC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);
// Check on every clock edge, reset included
`define DFSC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) expr) else $error(msg);
`else
`define DFSC_ASSERT(label, expr, msg)
`define DFSC_ASSERT_ALWAYS(label, expr, msg)
`endif

`endif

@@ rtl/core/dfsc_pkg.sv @@
`timescale 1ns / 1ps

package dfsc_pkg;

  // Configuration register indexes
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_MAX_REPEAT = 1'b1;

  // Register reset values
  localparam logic [15:0] CAPACITY_RESET   = 16'd1024;
  localparam logic [5:0]  MAX_REPEAT_RESET = 6'd15;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_DIGIT_POS  = 4'd1;
  localparam logic [3:0] ST_REPEAT_BIG = 4'd2;
  localparam logic [3:0] ST_OPEN_POS   = 4'd3;
  localparam logic [3:0] ST_CLOSE_POS  = 4'd4;
  localparam logic [3:0] ST_COMMA_POS  = 4'd5;
  localparam logic [3:0] ST_TYPE_POS   = 4'd6;
  localparam logic [3:0] ST_ILLEGAL    = 4'd7;
  localparam logic [3:0] ST_UNBALANCED = 4'd8;
  localparam logic [3:0] ST_FULL       = 4'd9;

  // Data-length kinds (code bits 15:14)
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_HALF = 2'd2;
  localparam logic [1:0] KIND_BYTE = 2'd3;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BIG_N = 8'h4E;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_M     = 8'h6D;

  // Type code of a type letter, zero for anything else
  function automatic logic [7:0] type_of(input logic [7:0] ch);
    logic [7:0] t;
    case (ch)
      8'h69:   t = 8'd1;   // i
      8'h46:   t = 8'd2;   // F
      8'h61:   t = 8'd3;   // a
      8'h53:   t = 8'd4;   // S
      8'h73:   t = 8'd5;   // s
      8'h43:   t = 8'd6;   // C
      8'h63:   t = 8'd7;   // c
      8'h44:   t = 8'd8;   // D
      8'h4C:   t = 8'd9;   // L
      8'h6C:   t = 8'd10;  // l
      8'h49:   t = 8'd11;  // I
      8'h41:   t = 8'd12;  // A
      default: t = 8'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/data_format_string_compiler_core.sv @@
`timescale 1ns / 1ps
`include "data_format_string_compiler_core_defines.svh"

// Format string compiler: takes a data-format string one ASCII character per
// transfer (s_tuser marks the first character and clears all parse state,
// s_tlast marks the final one and triggers the group balance check) and
// returns exactly one result per character: the 16-bit format code it
// produced, if any, with the sticky status, the running code count and a
// done flag. The result of a character is registered; a new character is
// accepted every cycle as long as the result register is empty or being
// drained in the same cycle. The per-character parse is a single level of
// logic over a few small state registers. Configuration (capacity, max
// repeat) must be written through cfg_we/cfg_addr/cfg_wdata only while no
// character is in flight; the block itself does not enforce this.
module data_format_string_compiler_core #(
  parameter int LEVEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Character input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic [0:0]  s_tuser,   // [0] first
  input  logic        s_tlast,   // last
  // Result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] code, [19:16] status, [35:20] code_count
  output logic [1:0]  m_tuser    // [0] code_valid, [1] done_res
);

  // Configuration registers
  logic [15:0] capacity;
  logic [5:0]  max_repeat;

  // Parse state
  logic [6:0]            repeat_acc;  // [6] token closed, [5:0] literal count
  logic [1:0]            data_kind;   // pending N/n/m kind, none when zero
  logic [LEVEL_BITS-1:0] nest_level;
  logic [15:0]           emitted;
  logic [3:0]            error_code;

  logic [6:0]            repeat_acc_next;
  logic [1:0]            data_kind_next;
  logic [LEVEL_BITS-1:0] nest_level_next;
  logic [15:0]           emitted_next;
  logic [3:0]            error_code_next;

  logic [15:0] code_next;
  logic        code_valid_next;
  logic        done_next;

  logic in_xfer;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // Per-character parse
  always_comb begin
    logic [7:0]            ch;
    logic [6:0]            rep0;
    logic [1:0]            kind0;
    logic [LEVEL_BITS-1:0] lvl0;
    logic [15:0]           emit0;
    logic [3:0]            err0;
    logic                  closed;
    logic [5:0]            cnt;
    logic [5:0]            cnt_lit;
    logic                  full;
    logic [7:0]            kf;
    logic [9:0]            digit_val;
    logic [3:0]            e;

    ch    = s_tdata;
    rep0  = s_tuser[0] ? 7'd0 : repeat_acc;
    kind0 = s_tuser[0] ? dfsc_pkg::KIND_NONE : data_kind;
    lvl0  = s_tuser[0] ? '0 : nest_level;
    emit0 = s_tuser[0] ? 16'd0 : emitted;
    err0  = s_tuser[0] ? dfsc_pkg::ST_OK : error_code;

    closed    = rep0[6];
    cnt       = rep0[5:0];
    cnt_lit   = (cnt > 6'd1) ? cnt : 6'd1;
    full      = emit0 >= capacity;
    kf        = dfsc_pkg::type_of(ch);
    digit_val = {1'b0, cnt, 3'b000} + {3'b000, cnt, 1'b0} + {6'd0, ch[3:0]};
    e         = dfsc_pkg::ST_OK;

    repeat_acc_next = rep0;
    data_kind_next  = kind0;
    nest_level_next = lvl0;
    emitted_next    = emit0;
    error_code_next = err0;
    code_next       = 16'd0;
    code_valid_next = 1'b0;

    if (err0 == dfsc_pkg::ST_OK) begin
      case (ch) inside
        dfsc_pkg::CH_SPACE: begin
        end
        [dfsc_pkg::CH_ZERO:dfsc_pkg::CH_NINE]: begin
          if (closed) begin
            e = dfsc_pkg::ST_DIGIT_POS;
          end else if (digit_val > {4'd0, max_repeat}) begin
            e = dfsc_pkg::ST_REPEAT_BIG;
          end else begin
            repeat_acc_next = {1'b0, digit_val[5:0]};
          end
        end
        dfsc_pkg::CH_OPEN: begin
          if (closed) begin
            e = dfsc_pkg::ST_OPEN_POS;
          end else if (full) begin
            e = dfsc_pkg::ST_FULL;
          end else begin
            code_next       = (kind0 != dfsc_pkg::KIND_NONE) ? {kind0, 14'd0}
                                                             : {2'b00, cnt_lit, 8'd0};
            code_valid_next = 1'b1;
            nest_level_next = lvl0 + {{(LEVEL_BITS-1){1'b0}}, 1'b1};
            data_kind_next  = dfsc_pkg::KIND_NONE;
            repeat_acc_next = 7'd0;
          end
        end
        dfsc_pkg::CH_CLOSE: begin
          if (!closed) begin
            e = dfsc_pkg::ST_CLOSE_POS;
          end else if (full) begin
            e = dfsc_pkg::ST_FULL;
          end else begin
            code_valid_next = 1'b1;
            nest_level_next = lvl0 - {{(LEVEL_BITS-1){1'b0}}, 1'b1};
            repeat_acc_next = 7'h40;
          end
        end
        dfsc_pkg::CH_COMMA: begin
          if (!closed) e = dfsc_pkg::ST_COMMA_POS;
          else repeat_acc_next = 7'd0;
        end
        dfsc_pkg::CH_BIG_N: data_kind_next = dfsc_pkg::KIND_WORD;
        dfsc_pkg::CH_N:     data_kind_next = dfsc_pkg::KIND_HALF;
        dfsc_pkg::CH_M:     data_kind_next = dfsc_pkg::KIND_BYTE;
        default: begin
          if (kf == 8'd0) begin
            e = dfsc_pkg::ST_ILLEGAL;
          end else if (closed) begin
            e = dfsc_pkg::ST_TYPE_POS;
          end else if (full) begin
            e = dfsc_pkg::ST_FULL;
          end else begin
            // data-driven count keeps a literal zero, plain count defaults to one
            code_next       = {kind0, (kind0 != dfsc_pkg::KIND_NONE) ? cnt : cnt_lit, kf};
            code_valid_next = 1'b1;
            data_kind_next  = dfsc_pkg::KIND_NONE;
            repeat_acc_next = 7'h40;
          end
        end
      endcase

      if (code_valid_next) emitted_next = emit0 + 16'd1;
      if (e == dfsc_pkg::ST_OK && s_tlast && nest_level_next != '0) begin
        e = dfsc_pkg::ST_UNBALANCED;
      end
      error_code_next = e;
    end

    done_next = s_tlast || (error_code_next != dfsc_pkg::ST_OK);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= dfsc_pkg::CAPACITY_RESET;
      max_repeat <= dfsc_pkg::MAX_REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dfsc_pkg::REG_CAPACITY:   capacity   <= cfg_wdata;
        dfsc_pkg::REG_MAX_REPEAT: max_repeat <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Parse state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_acc <= 7'd0;
      data_kind  <= dfsc_pkg::KIND_NONE;
      nest_level <= '0;
      emitted    <= 16'd0;
      error_code <= dfsc_pkg::ST_OK;
    end else if (in_xfer) begin
      repeat_acc <= repeat_acc_next;
      data_kind  <= data_kind_next;
      nest_level <= nest_level_next;
      emitted    <= emitted_next;
      error_code <= error_code_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {4'd0, emitted_next, error_code_next, code_next};
      m_tuser <= {done_next, code_valid_next};
    end
  end

  // Checks
  `DFSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `DFSC_ASSERT(a_code_status, m_tvalid && m_tuser[0] |-> m_tdata[19:16] == dfsc_pkg::ST_OK || m_tdata[19:16] == dfsc_pkg::ST_UNBALANCED, "code emitted with token error")
  `DFSC_ASSERT(a_no_code_zero, m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0, "code bits set without code_valid")
  `DFSC_ASSERT(a_error_done, m_tvalid && m_tdata[19:16] != dfsc_pkg::ST_OK |-> m_tuser[1], "error without done")
  `DFSC_ASSERT(a_error_sticky, in_xfer && !s_tuser[0] && error_code != dfsc_pkg::ST_OK |=> error_code == $past(error_code) && emitted == $past(emitted), "error state not sticky")

endmodule
